@@ sv/sclf_pkg.sv @@
package sclf_pkg;

   // one-hot controller states
   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_NEEDACCESS = 7'b0000010,
      ST_SEED       = 7'b0000100,
      ST_LOCKOUT    = 7'b0001000,
      ST_WAIT       = 7'b0010000,
      ST_DATANOK    = 7'b0100000,
      ST_WRITE      = 7'b1000000
   } state_type;

   // reported state codes
   localparam logic [2:0] CODE_IDLE       = 3'd0;
   localparam logic [2:0] CODE_NEEDACCESS = 3'd1;
   localparam logic [2:0] CODE_SEED       = 3'd2;
   localparam logic [2:0] CODE_LOCKOUT    = 3'd3;
   localparam logic [2:0] CODE_WAIT       = 3'd4;
   localparam logic [2:0] CODE_DATANOK    = 3'd5;
   localparam logic [2:0] CODE_WRITE      = 3'd6;

   // access status codes
   localparam logic [2:0] ACC_REQ_OK  = 3'd1;
   localparam logic [2:0] ACC_REQ_NOK = 3'd2;
   localparam logic [2:0] ACC_ENABLE  = 3'd3;
   localparam logic [2:0] ACC_PROGRAM = 3'd4;

   // operation codes
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_REINIT = 1'b1;

   // save request codes
   localparam logic [1:0] SAVE_NONE = 2'd0;
   localparam logic [1:0] SAVE_FLAG = 2'd1;
   localparam logic [1:0] SAVE_DATA = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_LOCKOUT_DELAY = 3'd0;
   localparam logic [2:0] CSR_DEF_UC        = 3'd1;
   localparam logic [2:0] CSR_DEF_ALT       = 3'd2;
   localparam logic [2:0] CSR_DEF_FRIC      = 3'd3;
   localparam logic [2:0] CSR_DEF_GEAR      = 3'd4;
   localparam logic [2:0] CSR_DEF_PRESS     = 3'd5;
   localparam logic [2:0] CSR_DEF_CAR       = 3'd6;
   localparam logic [2:0] CSR_DEF_HEAT      = 3'd7;

   localparam int unsigned CSR_WIDTH = 24;
   localparam logic [15:0] DELAY_RESET = 16'd30000;
   localparam logic [14:0] DELAY_CAP   = 15'd30000;
   localparam logic [7:0]  COUNT_MAX   = 8'd255;
   localparam logic [7:0]  REINIT_ID   = 8'd2;

   typedef struct packed {
      logic [15:0] lockout_delay;
      logic [23:0] def_uc;
      logic [15:0] def_alternator;
      logic [7:0]  def_fric;
      logic [7:0]  def_gear_box;
      logic [7:0]  def_press_clim;
      logic [7:0]  def_car;
      logic [7:0]  def_add_heat;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic [2:0]  access_status;
      logic        data_valid;
      logic        write_confirmed;
      logic        main_wakeup;
      logic        assembly_mode;
      logic [63:0] raw_low;
      logic [23:0] raw_high;
   } item_type;

   typedef struct packed {
      logic [2:0]  ecu_state;
      logic        anti_scan_active;
      logic [1:0]  save_request;
      logic [7:0]  coding_count;
      logic [7:0]  coded_id;
      logic [7:0]  coded_fric;
      logic [7:0]  coded_press_clim;
      logic [7:0]  coded_gear_box;
      logic [15:0] coded_alternator;
      logic [7:0]  coded_car;
      logic [7:0]  coded_add_heat;
      logic [23:0] coded_uc;
   } result_type;

endpackage

@@ sv/secure_coding_lockout_fsm.sv @@
// path: a request goes through the input register, then the output register, to rsp
// throughput: one request per cycle while rsp is not stalled; the controller state
//   updates as a request leaves the input register, so the next request sees it
// reset: synchronous, active high; state idle, flag, timer, counter and id cleared,
//   lockout delay 30000, default and coded values zero, both channels empty
module secure_coding_lockout_fsm (
   input  logic                               clock,
   input  logic                               reset,
   // config write port
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [sclf_pkg::CSR_WIDTH-1:0]     csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // access_status[2:0], data_valid[3], write_confirmed[4], main_wakeup[5],
   // assembly_mode[6], raw_low[70:7], raw_high[94:71], zero pad[95]
   input  logic [95:0]                        req_tdata,
   // operation[0]
   input  logic                               req_tuser,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // ecu_state[2:0], anti_scan_active[3], save_request[5:4], coding_count[13:6],
   // coded_id[21:14], coded_fric[29:22], coded_press_clim[37:30],
   // coded_gear_box[45:38], coded_alternator[61:46], coded_car[69:62],
   // coded_add_heat[77:70], coded_uc[101:78], zero pad[103:102]
   output logic [103:0]                       rsp_tdata
);
   import sclf_pkg::*;

   cfg_type    cfg_ff;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       step;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_delay  <= DELAY_RESET;
         cfg_ff.def_uc         <= '0;
         cfg_ff.def_alternator <= '0;
         cfg_ff.def_fric       <= '0;
         cfg_ff.def_gear_box   <= '0;
         cfg_ff.def_press_clim <= '0;
         cfg_ff.def_car        <= '0;
         cfg_ff.def_add_heat   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCKOUT_DELAY: cfg_ff.lockout_delay  <= csr_wdata[15:0];
            CSR_DEF_UC:        cfg_ff.def_uc         <= csr_wdata[23:0];
            CSR_DEF_ALT:       cfg_ff.def_alternator <= csr_wdata[15:0];
            CSR_DEF_FRIC:      cfg_ff.def_fric       <= csr_wdata[7:0];
            CSR_DEF_GEAR:      cfg_ff.def_gear_box   <= csr_wdata[7:0];
            CSR_DEF_PRESS:     cfg_ff.def_press_clim <= csr_wdata[7:0];
            CSR_DEF_CAR:       cfg_ff.def_car        <= csr_wdata[7:0];
            CSR_DEF_HEAT:      cfg_ff.def_add_heat   <= csr_wdata[7:0];
            default:           cfg_ff.def_add_heat   <= cfg_ff.def_add_heat;
         endcase
      end
   end

   // handshake: input register drains into the output register
   assign step       = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.operation       <= req_tuser;
         item_ff.access_status   <= req_tdata[2:0];
         item_ff.data_valid      <= req_tdata[3];
         item_ff.write_confirmed <= req_tdata[4];
         item_ff.main_wakeup     <= req_tdata[5];
         item_ff.assembly_mode   <= req_tdata[6];
         item_ff.raw_low         <= req_tdata[70:7];
         item_ff.raw_high        <= req_tdata[94:71];
      end
   end

   sclf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .item   (item_ff),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.coded_uc,
                        rsp_ff.coded_add_heat,
                        rsp_ff.coded_car,
                        rsp_ff.coded_alternator,
                        rsp_ff.coded_gear_box,
                        rsp_ff.coded_press_clim,
                        rsp_ff.coded_fric,
                        rsp_ff.coded_id,
                        rsp_ff.coding_count,
                        rsp_ff.save_request,
                        rsp_ff.anti_scan_active,
                        rsp_ff.ecu_state};

endmodule

@@ sv/sclf_core.sv @@
module sclf_core (
   input  logic                clock,
   input  logic                reset,
   input  sclf_pkg::cfg_type   cfg,
   input  logic                step,
   input  sclf_pkg::item_type  item,
   output sclf_pkg::result_type result
);
   import sclf_pkg::*;

   state_type   state_ff, state_in;
   logic        flag_ff, flag_in;
   logic [14:0] timer_ff, timer_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  fric_ff, fric_in;
   logic [7:0]  press_ff, press_in;
   logic [7:0]  gear_ff, gear_in;
   logic [7:0]  car_ff, car_in;
   logic [7:0]  heat_ff, heat_in;
   logic [15:0] alt_ff, alt_in;
   logic [23:0] uc_ff, uc_in;
   logic [1:0]  save;
   logic [14:0] delay_clamped;
   logic [14:0] timer_dec;
   logic [2:0]  state_code;

   // lockout load value and countdown
   assign delay_clamped = (cfg.lockout_delay > {1'b0, DELAY_CAP}) ? DELAY_CAP
                                                                  : cfg.lockout_delay[14:0];
   assign timer_dec     = (timer_ff - 15'd1 > DELAY_CAP) ? DELAY_CAP : timer_ff - 15'd1;

   // next state and coded values for one request
   always_comb begin
      state_in = state_ff;
      flag_in  = flag_ff;
      timer_in = timer_ff;
      count_in = count_ff;
      id_in    = id_ff;
      fric_in  = fric_ff;
      press_in = press_ff;
      gear_in  = gear_ff;
      car_in   = car_ff;
      heat_in  = heat_ff;
      alt_in   = alt_ff;
      uc_in    = uc_ff;
      save     = SAVE_NONE;
      if (item.operation == OP_REINIT) begin
         fric_in  = cfg.def_fric;
         press_in = cfg.def_press_clim;
         gear_in  = cfg.def_gear_box;
         car_in   = cfg.def_car;
         heat_in  = cfg.def_add_heat;
         alt_in   = cfg.def_alternator;
         uc_in    = cfg.def_uc;
         count_in = '0;
         id_in    = REINIT_ID;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (flag_ff) begin
                  state_in = ST_LOCKOUT;
                  save     = SAVE_FLAG;
                  timer_in = delay_clamped;
               end else begin
                  state_in = (count_ff == 8'd0) ? ST_WAIT : ST_NEEDACCESS;
               end
            end
            ST_NEEDACCESS: begin
               if (item.access_status == ACC_REQ_OK) begin
                  state_in = ST_SEED;
               end else if (item.access_status == ACC_ENABLE) begin
                  state_in = ST_WAIT;
               end
            end
            ST_SEED: begin
               if ((flag_ff && item.access_status != ACC_ENABLE) ||
                   item.access_status == ACC_REQ_NOK) begin
                  flag_in  = 1'b1;
                  save     = SAVE_FLAG;
                  state_in = ST_LOCKOUT;
                  timer_in = delay_clamped;
               end else if (item.access_status == ACC_ENABLE) begin
                  state_in = ST_WAIT;
               end
            end
            ST_LOCKOUT: begin
               if (timer_ff == 15'd0) begin
                  flag_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  timer_in = timer_dec;
               end
            end
            ST_WAIT: begin
               if (item.access_status == ACC_PROGRAM) begin
                  state_in = item.data_valid ? ST_WRITE : ST_DATANOK;
               end else if (!item.main_wakeup || !item.assembly_mode ||
                            (item.access_status != ACC_ENABLE && count_ff != 8'd0)) begin
                  state_in = ST_IDLE;
               end
            end
            ST_DATANOK, ST_WRITE: begin
               if (item.write_confirmed) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase

         // unpack raw bytes on write entry
         if (state_in == ST_WRITE && state_ff != ST_WRITE) begin
            id_in    = item.raw_low[7:0];
            fric_in  = item.raw_low[15:8];
            press_in = item.raw_low[23:16];
            gear_in  = item.raw_low[31:24];
            alt_in   = item.raw_low[47:32];
            car_in   = item.raw_low[55:48];
            heat_in  = item.raw_low[63:56];
            uc_in    = item.raw_high;
            count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;
            save     = SAVE_DATA;
         end
      end
   end

   // controller and coding registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flag_ff  <= 1'b0;
         timer_ff <= '0;
         count_ff <= '0;
         id_ff    <= '0;
         fric_ff  <= '0;
         press_ff <= '0;
         gear_ff  <= '0;
         car_ff   <= '0;
         heat_ff  <= '0;
         alt_ff   <= '0;
         uc_ff    <= '0;
      end else if (step) begin
         state_ff <= state_in;
         flag_ff  <= flag_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         fric_ff  <= fric_in;
         press_ff <= press_in;
         gear_ff  <= gear_in;
         car_ff   <= car_in;
         heat_ff  <= heat_in;
         alt_ff   <= alt_in;
         uc_ff    <= uc_in;
      end
   end

   // state encoding for the result
   always_comb begin
      unique case (state_in)
         ST_IDLE:       state_code = CODE_IDLE;
         ST_NEEDACCESS: state_code = CODE_NEEDACCESS;
         ST_SEED:       state_code = CODE_SEED;
         ST_LOCKOUT:    state_code = CODE_LOCKOUT;
         ST_WAIT:       state_code = CODE_WAIT;
         ST_DATANOK:    state_code = CODE_DATANOK;
         ST_WRITE:      state_code = CODE_WRITE;
         default:       state_code = CODE_IDLE;
      endcase
   end

   assign result.ecu_state        = state_code;
   assign result.anti_scan_active = flag_in;
   assign result.save_request     = save;
   assign result.coding_count     = count_in;
   assign result.coded_id         = id_in;
   assign result.coded_fric       = fric_in;
   assign result.coded_press_clim = press_in;
   assign result.coded_gear_box   = gear_in;
   assign result.coded_alternator = alt_in;
   assign result.coded_car        = car_in;
   assign result.coded_add_heat   = heat_in;
   assign result.coded_uc         = uc_in;

endmodule

@@ tb/secure_coding_lockout_fsm_tb.sv @@
`timescale 1ns / 100ps

module secure_coding_lockout_fsm_tb;
   import sclf_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 800;
   localparam int SETTLE_CYCLES = 4;
   localparam int LOCKOUT_TICKS = 40;
   localparam logic [2:0] ACC_OTHER = 3'd0;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [2:0]           csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [95:0]          req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [103:0]         rsp_tdata;

   secure_coding_lockout_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow copy of the registers and the controller
   cfg_type     cfg;
   logic [2:0]  ctl_state;
   logic        ctl_flag;
   logic [14:0] ctl_timer;
   logic [7:0]  ctl_count;
   logic [7:0]  ctl_id;
   logic [7:0]  ctl_fric;
   logic [7:0]  ctl_press;
   logic [7:0]  ctl_gear;
   logic [7:0]  ctl_car;
   logic [7:0]  ctl_heat;
   logic [15:0] ctl_alt;
   logic [23:0] ctl_uc;

   result_type  expected_codings[$];
   int          mismatches;
   bit          idle_on;
   int          rsp_hold_left;
   int          rsp_off_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void restore_coded_defaults();
      ctl_fric  = cfg.def_fric;
      ctl_press = cfg.def_press_clim;
      ctl_gear  = cfg.def_gear_box;
      ctl_car   = cfg.def_car;
      ctl_heat  = cfg.def_add_heat;
      ctl_alt   = cfg.def_alternator;
      ctl_uc    = cfg.def_uc;
   endfunction

   // lockout delay as loaded into the timer
   function automatic logic [14:0] lockout_load();
      return (cfg.lockout_delay > {1'b0, DELAY_CAP}) ? DELAY_CAP : cfg.lockout_delay[14:0];
   endfunction

   // one tick or reinit of the controller, returns the coding status that follows
   function automatic result_type predict_coding_step(item_type it);
      result_type  r;
      logic [2:0]  prev;
      logic [2:0]  nxt;
      logic [14:0] t;
      logic [1:0]  save;
      save = SAVE_NONE;
      if (it.operation == OP_REINIT) begin
         restore_coded_defaults();
         ctl_count = 8'd0;
         ctl_id    = REINIT_ID;
      end else begin
         prev = ctl_state;
         nxt  = prev;
         case (prev)
            CODE_IDLE: begin
               if (ctl_flag) begin
                  nxt       = CODE_LOCKOUT;
                  save      = SAVE_FLAG;
                  ctl_timer = lockout_load();
               end else begin
                  nxt = (ctl_count == 8'd0) ? CODE_WAIT : CODE_NEEDACCESS;
               end
            end
            CODE_NEEDACCESS: begin
               if (it.access_status == ACC_REQ_OK) nxt = CODE_SEED;
               else if (it.access_status == ACC_ENABLE) nxt = CODE_WAIT;
            end
            CODE_SEED: begin
               if ((ctl_flag && it.access_status != ACC_ENABLE) ||
                   it.access_status == ACC_REQ_NOK) begin
                  ctl_flag  = 1'b1;
                  save      = SAVE_FLAG;
                  nxt       = CODE_LOCKOUT;
                  ctl_timer = lockout_load();
               end else if (it.access_status == ACC_ENABLE) begin
                  nxt = CODE_WAIT;
               end
            end
            CODE_LOCKOUT: begin
               if (ctl_timer == 15'd0) begin
                  ctl_flag = 1'b0;
                  nxt      = CODE_IDLE;
               end else begin
                  t         = ctl_timer - 15'd1;
                  ctl_timer = (t > DELAY_CAP) ? DELAY_CAP : t;
               end
            end
            CODE_WAIT: begin
               if (it.access_status == ACC_PROGRAM) begin
                  nxt = it.data_valid ? CODE_WRITE : CODE_DATANOK;
               end else if (!it.main_wakeup || !it.assembly_mode ||
                            (it.access_status != ACC_ENABLE && ctl_count != 8'd0)) begin
                  nxt = CODE_IDLE;
               end
            end
            CODE_DATANOK, CODE_WRITE: begin
               if (it.write_confirmed) nxt = CODE_IDLE;
            end
            default: nxt = CODE_IDLE;
         endcase
         ctl_state = nxt;

         // raw bytes are unpacked only when write is entered
         if (nxt == CODE_WRITE && prev != CODE_WRITE) begin
            ctl_id    = it.raw_low[7:0];
            ctl_fric  = it.raw_low[15:8];
            ctl_press = it.raw_low[23:16];
            ctl_gear  = it.raw_low[31:24];
            ctl_alt   = it.raw_low[47:32];
            ctl_car   = it.raw_low[55:48];
            ctl_heat  = it.raw_low[63:56];
            ctl_uc    = it.raw_high;
            if (ctl_count < COUNT_MAX) ctl_count = ctl_count + 8'd1;
            save = SAVE_DATA;
         end
      end
      r.ecu_state        = ctl_state;
      r.anti_scan_active = ctl_flag;
      r.save_request     = save;
      r.coding_count     = ctl_count;
      r.coded_id         = ctl_id;
      r.coded_fric       = ctl_fric;
      r.coded_press_clim = ctl_press;
      r.coded_gear_box   = ctl_gear;
      r.coded_alternator = ctl_alt;
      r.coded_car        = ctl_car;
      r.coded_add_heat   = ctl_heat;
      r.coded_uc         = ctl_uc;
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic item_type make_request(logic op, logic [2:0] acc, logic dv,
                                             logic wc, logic wku, logic afts);
      item_type it;
      it.operation       = op;
      it.access_status   = acc;
      it.data_valid      = dv;
      it.write_confirmed = wc;
      it.main_wakeup     = wku;
      it.assembly_mode   = afts;
      it.raw_low         = {$urandom, $urandom};
      it.raw_high        = 24'($urandom);
      return it;
   endfunction

   // random request, steered by the current state so that codings get through
   function automatic item_type pick_request(int guided_pct, int reinit_pct);
      item_type it;
      int       r;
      it = make_request(OP_TICK, 3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom));
      if ($urandom_range(0, 99) < reinit_pct) it.operation = OP_REINIT;
      if ($urandom_range(0, 99) < guided_pct) begin
         r = $urandom_range(0, 99);
         case (ctl_state)
            CODE_NEEDACCESS: begin
               if (r < 50) it.access_status = ACC_REQ_OK;
               else if (r < 80) it.access_status = ACC_ENABLE;
            end
            CODE_SEED: begin
               if (r < 55) it.access_status = ACC_ENABLE;
               else if (r < 80) it.access_status = ACC_REQ_NOK;
            end
            CODE_WAIT: begin
               if ($urandom_range(0, 99) < 90) begin
                  it.main_wakeup   = 1'b1;
                  it.assembly_mode = 1'b1;
               end
               if (r < 50) begin
                  it.access_status = ACC_PROGRAM;
                  it.data_valid    = ($urandom_range(0, 99) < 75);
               end else if (r < 80) begin
                  it.access_status = ACC_ENABLE;
               end
            end
            CODE_DATANOK, CODE_WRITE: it.write_confirmed = (r < 40);
            default: ;
         endcase
      end
      return it;
   endfunction

   // shortest path round the coding loop: need access, wait, write, idle
   function automatic item_type quick_request();
      item_type it;
      it = make_request(OP_TICK, ACC_ENABLE, 1'b1, 1'b1, 1'b1, 1'b1);
      if (ctl_state == CODE_WAIT) it.access_status = ACC_PROGRAM;
      return it;
   endfunction

   // offer one request and record its expected status once accepted
   task automatic send_request(input item_type it);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.operation;
      req_tdata  = {1'b0, it.raw_high, it.raw_low, it.assembly_mode, it.main_wakeup,
                    it.write_confirmed, it.data_valid, it.access_status};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_codings.push_back(predict_coding_step(it));
   endtask

   // stop offering and let every outstanding request come back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_codings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [23:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         CSR_LOCKOUT_DELAY: cfg.lockout_delay  = value[15:0];
         CSR_DEF_UC:        cfg.def_uc         = value;
         CSR_DEF_ALT:       cfg.def_alternator = value[15:0];
         CSR_DEF_FRIC:      cfg.def_fric       = value[7:0];
         CSR_DEF_GEAR:      cfg.def_gear_box   = value[7:0];
         CSR_DEF_PRESS:     cfg.def_press_clim = value[7:0];
         CSR_DEF_CAR:       cfg.def_car        = value[7:0];
         CSR_DEF_HEAT:      cfg.def_add_heat   = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic write_delay(input logic [15:0] delay);
      write_register(CSR_LOCKOUT_DELAY, {8'($urandom), delay});
   endtask

   task automatic write_defaults(input logic [23:0] uc, input logic [15:0] alt,
                                 input logic [7:0] fric, input logic [7:0] gear,
                                 input logic [7:0] press, input logic [7:0] car,
                                 input logic [7:0] heat);
      write_register(CSR_DEF_UC, uc);
      write_register(CSR_DEF_ALT, {8'($urandom), alt});
      write_register(CSR_DEF_FRIC, {16'($urandom), fric});
      write_register(CSR_DEF_GEAR, {16'($urandom), gear});
      write_register(CSR_DEF_PRESS, {16'($urandom), press});
      write_register(CSR_DEF_CAR, {16'($urandom), car});
      write_register(CSR_DEF_HEAT, {16'($urandom), heat});
   endtask

   task automatic run_random(input int count, input int guided_pct, input int reinit_pct);
      repeat (count) send_request(pick_request(guided_pct, reinit_pct));
   endtask

   // walk the controller until a rejected seed locks it out
   task automatic drive_into_lockout();
      item_type it;
      while (ctl_state != CODE_LOCKOUT) begin
         it = pick_request(100, 0);
         if (ctl_state == CODE_SEED) it.access_status = ACC_REQ_NOK;
         send_request(it);
      end
   endtask

   // reset values: idle goes to wait while no coding was done yet
   task automatic test_reset_state();
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_ENABLE, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b1, 1'b0));
   endtask

   // defaults take effect only on reinit
   task automatic test_defaults_reinit();
      wait_for_results();
      write_delay(16'd3);
      write_defaults(24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(make_request(OP_TICK, ACC_ENABLE, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_request(OP_REINIT, ACC_OTHER, 1'b1, 1'b1, 1'b1, 1'b1));
      wait_for_results();
      write_defaults(24'h000001, 16'h8000, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h10);
      send_request(make_request(OP_REINIT, ACC_PROGRAM, 1'b0, 1'b0, 1'b0, 1'b0));
   endtask

   // write entry unpacking, write hold, data bad and the access paths
   task automatic test_write_entry();
      item_type it;
      it = make_request(OP_TICK, ACC_PROGRAM, 1'b1, 1'b0, 1'b0, 1'b0);
      it.raw_low  = '1;
      it.raw_high = '1;
      send_request(it);
      // staying in write must not reload the fields
      it = make_request(OP_TICK, ACC_PROGRAM, 1'b1, 1'b0, 1'b1, 1'b1);
      it.raw_low  = '0;
      it.raw_high = '0;
      send_request(it);
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b1, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      // unknown access codes behave as other
      for (int code = ACC_PROGRAM + 1; code <= 7; code++)
         send_request(make_request(OP_TICK, 3'(code), 1'b1, 1'b1, 1'b1, 1'b1));
      send_request(make_request(OP_TICK, ACC_REQ_OK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_ENABLE, 1'b0, 1'b0, 1'b0, 1'b0));
      it = make_request(OP_TICK, ACC_PROGRAM, 1'b1, 1'b0, 1'b0, 1'b0);
      it.raw_low  = 64'h0706050403020100;
      it.raw_high = 24'h0A0908;
      send_request(it);
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b1, 1'b0, 1'b0));
      // wait falls back to idle once a coding exists and access is not enabled
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_ENABLE, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b1, 1'b1));
      // program with invalid data goes to data bad
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_ENABLE, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_PROGRAM, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_request(OP_TICK, ACC_PROGRAM, 1'b1, 1'b0, 1'b1, 1'b1));
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b1, 1'b0, 1'b0));
   endtask

   // rejected seed, countdown, reinit inside lockout, zero delay
   task automatic test_lockout();
      send_request(make_request(OP_TICK, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_REQ_OK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_TICK, ACC_REQ_NOK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_request(make_request(OP_REINIT, ACC_ENABLE, 1'b1, 1'b1, 1'b1, 1'b1));
      while (ctl_state == CODE_LOCKOUT) send_request(pick_request(0, 0));
      wait_for_results();
      write_delay(16'd0);
      drive_into_lockout();
      while (ctl_state == CODE_LOCKOUT) send_request(pick_request(0, 0));
   endtask

   // receiver holds off, block fills up, then the receiver drains it
   task automatic test_backpressure();
      wait_for_results();
      write_delay(16'd4);
      idle_on = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      run_random(40, 90, 2);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random_settings();
      // short lockout, random defaults
      wait_for_results();
      write_delay(16'($urandom_range(1, 8)));
      write_defaults(24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
      run_random(60, 85, 3);
      idle_on = 1'b0;
      run_random(20, 85, 3);
      idle_on = 1'b1;
      // zero delay, zero defaults
      wait_for_results();
      write_delay(16'd0);
      write_defaults(24'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0);
      run_random(60, 85, 3);
      // all-ones defaults, more noise
      wait_for_results();
      write_delay(16'd1);
      write_defaults(24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      run_random(60, 70, 5);
   endtask

   // coding counter saturates at its maximum
   task automatic test_count_saturation();
      wait_for_results();
      write_delay(16'd2);
      while (ctl_count != COUNT_MAX) send_request(quick_request());
      run_random(20, 100, 0);
      send_request(make_request(OP_REINIT, ACC_OTHER, 1'b0, 1'b0, 1'b0, 1'b0));
   endtask

   // largest delay is clamped to the cap and the lockout holds
   task automatic test_long_lockout();
      wait_for_results();
      write_register(CSR_LOCKOUT_DELAY, 24'hFFFFFF);
      idle_on = 1'b0;
      drive_into_lockout();
      repeat (LOCKOUT_TICKS) send_request(pick_request(0, 1));
      idle_on = 1'b1;
   endtask

   // receiver: random ready, plus a long hold-off on request
   initial begin
      rsp_tready    = 1'b0;
      rsp_off_left  = 0;
      rsp_hold_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready    = 1'b0;
            rsp_hold_left = rsp_hold_left - 1;
         end else if (rsp_off_left > 0) begin
            rsp_tready   = 1'b0;
            rsp_off_left = rsp_off_left - 1;
         end else if (idle_on && $urandom_range(0, 99) < 25) begin
            rsp_tready   = 1'b0;
            rsp_off_left = pick_gap();
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // compare each status against the oldest expectation
   initial begin
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            if (expected_codings.size() == 0) begin
               $error("status %0h arrived with nothing expected", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_codings.pop_front();
               check_field("ecu_state", 24'(want.ecu_state), 24'(rsp_tdata[2:0]));
               check_field("anti_scan_active", 24'(want.anti_scan_active),
                           24'(rsp_tdata[3]));
               check_field("save_request", 24'(want.save_request), 24'(rsp_tdata[5:4]));
               check_field("coding_count", 24'(want.coding_count), 24'(rsp_tdata[13:6]));
               check_field("coded_id", 24'(want.coded_id), 24'(rsp_tdata[21:14]));
               check_field("coded_fric", 24'(want.coded_fric), 24'(rsp_tdata[29:22]));
               check_field("coded_press_clim", 24'(want.coded_press_clim),
                           24'(rsp_tdata[37:30]));
               check_field("coded_gear_box", 24'(want.coded_gear_box),
                           24'(rsp_tdata[45:38]));
               check_field("coded_alternator", 24'(want.coded_alternator),
                           24'(rsp_tdata[61:46]));
               check_field("coded_car", 24'(want.coded_car), 24'(rsp_tdata[69:62]));
               check_field("coded_add_heat", 24'(want.coded_add_heat),
                           24'(rsp_tdata[77:70]));
               check_field("coded_uc", want.coded_uc, rsp_tdata[101:78]);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // main sequence
   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_LOCKOUT_DELAY;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      mismatches = 0;
      idle_on    = 1'b1;
      cfg        = '0;
      cfg.lockout_delay = DELAY_RESET;
      ctl_state  = CODE_IDLE;
      ctl_flag   = 1'b0;
      ctl_timer  = 15'd0;
      ctl_count  = 8'd0;
      ctl_id     = 8'd0;
      restore_coded_defaults();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_defaults_reinit();
      test_write_entry();
      test_lockout();
      test_backpressure();
      test_random_settings();
      test_count_saturation();
      test_long_lockout();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_codings.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
